### rtl/bpc_pkg.sv
`default_nettype none

package bpc_pkg;

   // widths fixed by the sensor scheme
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned RAW_W      = 19;
   localparam int unsigned UT_W       = 16;
   localparam int unsigned OSS_W      = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   typedef logic [WORD_W-1:0] word_type;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OVERSAMPLING    = 2'd0,
      CSR_CAL_TEMPERATURE = 2'd1,
      CSR_CAL_PRESSURE_A  = 2'd2,
      CSR_CAL_PRESSURE_B  = 2'd3
   } csr_index_type;

   // item kinds
   localparam logic OP_TEMPERATURE = 1'b0;
   localparam logic OP_PRESSURE    = 1'b1;

   // compensation constants
   localparam word_type B6_OFFSET   = 32'd4000;
   localparam word_type B4_BIAS     = 32'd32768;
   localparam word_type B7_SCALE    = 32'd50000;
   localparam word_type P_COEF_SQ   = 32'd3038;
   localparam word_type P_COEF_LIN  = 32'hFFFF_E343;   // -7357
   localparam word_type P_COEF_OFS  = 32'd3791;
   localparam word_type ROUND_T     = 32'd8;
   localparam word_type ROUND_2     = 32'd2;

   typedef struct packed {
      logic [OSS_W-1:0] oversampling;
      logic [63:0]      cal_temperature;
      logic [63:0]      cal_pressure_a;
      logic [31:0]      cal_pressure_b;
   } cfg_type;

   // request to the shared divider
   typedef struct packed {
      logic start;
      logic signed_mode;
   } div_req_type;

   function automatic word_type sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic word_type zx16(input logic [15:0] v);
      return {16'b0, v};
   endfunction

   function automatic word_type b7_scale(input logic [OSS_W-1:0] oss);
      return B7_SCALE >> oss;
   endfunction

endpackage

`default_nettype wire

### rtl/bpc_req_if.sv
`default_nettype none

interface bpc_req_if import bpc_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             operation;
   logic [RAW_W-1:0] raw_reading;

   modport source (output valid, output operation, output raw_reading, input ready);
   modport sink   (input valid, input operation, input raw_reading, output ready);
endinterface

`default_nettype wire

### rtl/bpc_rsp_if.sv
`default_nettype none

interface bpc_rsp_if import bpc_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic signed [WORD_W-1:0] compensated_value;
   logic        divide_error;

   modport source (output valid, output result_kind, output compensated_value,
                   output divide_error, input ready);
   modport sink   (input valid, input result_kind, input compensated_value,
                   input divide_error, output ready);
endinterface

`default_nettype wire

### rtl/bpc_mul.sv
`default_nettype none

module bpc_mul import bpc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     enable,
   input  wire word_type a,
   input  wire word_type b,
   output word_type      product
);

   word_type product_ff;
   word_type product_in;

   // low word of the product, wraps like the datasheet arithmetic
   assign product_in = a * b;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

`default_nettype wire

### rtl/bpc_div.sv
`default_nettype none

module bpc_div import bpc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   input  wire word_type    dividend,
   input  wire word_type    divisor,
   output logic             done,
   output word_type         quotient
);

   localparam int unsigned COUNT_W = $clog2(WORD_W + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic               neg_ff, neg_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   word_type           rem_ff, rem_in;
   word_type           quo_ff, quo_in;
   word_type           dvs_ff, dvs_in;

   logic [WORD_W:0]    shifted;
   logic [WORD_W+1:0]  trial;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign trial   = {1'b0, shifted} - {2'b0, dvs_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      if (req.start) begin
         // take magnitudes for a signed divide, remember the sign
         busy_in  = 1'b1;
         count_in = COUNT_W'(WORD_W);
         rem_in   = '0;
         quo_in   = (req.signed_mode && dividend[WORD_W-1]) ? -dividend : dividend;
         dvs_in   = (req.signed_mode && divisor[WORD_W-1]) ? -divisor : divisor;
         neg_in   = req.signed_mode && (dividend[WORD_W-1] ^ divisor[WORD_W-1]);
      end else if (busy_ff && count_ff != '0) begin
         count_in = count_ff - COUNT_W'(1);
         if (!trial[WORD_W+1]) begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
      end else if (busy_ff) begin
         // apply the sign and finish
         quo_in  = neg_ff ? -quo_ff : quo_ff;
         busy_in = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // a new divide never lands on one in flight
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      req.start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a divide");

   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> count_ff == '0 || $past(req.start) == 1'b0 && count_ff == '0)
      else $error("divider count left over while idle");

endmodule

`default_nettype wire

### rtl/bpc_seq.sv
`default_nettype none

module bpc_seq import bpc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   bpc_req_if.sink      req_port,
   bpc_rsp_if.source    rsp_port
);

   localparam int unsigned STATE_W = 33;

   typedef enum logic [STATE_W-1:0] {
      ST_IDLE    = 33'h1 << 0,
      ST_T_DIFF  = 33'h1 << 1,
      ST_T_MUL   = 33'h1 << 2,
      ST_T_X1    = 33'h1 << 3,
      ST_T_DEN   = 33'h1 << 4,
      ST_T_CHK   = 33'h1 << 5,
      ST_T_DWAIT = 33'h1 << 6,
      ST_T_OUT   = 33'h1 << 7,
      ST_P_B6    = 33'h1 << 8,
      ST_P_SQM   = 33'h1 << 9,
      ST_P_SQ    = 33'h1 << 10,
      ST_P_X1M   = 33'h1 << 11,
      ST_P_X1    = 33'h1 << 12,
      ST_P_X3    = 33'h1 << 13,
      ST_P_B3A   = 33'h1 << 14,
      ST_P_B3B   = 33'h1 << 15,
      ST_P_X3B   = 33'h1 << 16,
      ST_P_X3C   = 33'h1 << 17,
      ST_P_X3D   = 33'h1 << 18,
      ST_P_B4M   = 33'h1 << 19,
      ST_P_B4    = 33'h1 << 20,
      ST_P_B7A   = 33'h1 << 21,
      ST_P_B7M   = 33'h1 << 22,
      ST_P_B7    = 33'h1 << 23,
      ST_P_DWAIT = 33'h1 << 24,
      ST_P_F1M   = 33'h1 << 25,
      ST_P_F1    = 33'h1 << 26,
      ST_P_F1S   = 33'h1 << 27,
      ST_P_F2    = 33'h1 << 28,
      ST_P_S1    = 33'h1 << 29,
      ST_P_S2    = 33'h1 << 30,
      ST_P_FIN   = 33'h1 << 31,
      ST_DONE    = 33'h1 << 32
   } state_type;

   state_type        state_ff, state_in;
   logic             op_ff, op_in;
   logic [RAW_W-1:0] raw_ff, raw_in;
   word_type         r0_ff, r0_in;
   word_type         r1_ff, r1_in;
   word_type         r2_ff, r2_in;
   word_type         r3_ff, r3_in;
   word_type         b5_ff, b5_in;
   word_type         val_ff, val_in;
   logic             err_ff, err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_kind_ff, rsp_kind_in;
   word_type         rsp_value_ff, rsp_value_in;
   logic             rsp_err_ff, rsp_err_in;

   logic             mul_en;
   word_type         mul_a, mul_b, prod;
   div_req_type      div_req;
   word_type         div_dividend, div_divisor, quot;
   logic             div_done;
   logic             accept;

   word_type ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2;

   // unpack calibration words
   assign ac5 = zx16(cfg.cal_temperature[63:48]);
   assign ac6 = zx16(cfg.cal_temperature[47:32]);
   assign mc  = sx16(cfg.cal_temperature[31:16]);
   assign md  = sx16(cfg.cal_temperature[15:0]);
   assign ac1 = sx16(cfg.cal_pressure_a[63:48]);
   assign ac2 = sx16(cfg.cal_pressure_a[47:32]);
   assign ac3 = sx16(cfg.cal_pressure_a[31:16]);
   assign ac4 = zx16(cfg.cal_pressure_a[15:0]);
   assign b1  = sx16(cfg.cal_pressure_b[31:16]);
   assign b2  = sx16(cfg.cal_pressure_b[15:0]);

   bpc_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .a       (mul_a),
      .b       (mul_b),
      .product (prod)
   );

   bpc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quot)
   );

   assign req_port.ready = (state_ff == ST_IDLE);
   assign accept         = req_port.valid && req_port.ready;

   // one step per cycle except in divide and output waits
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      raw_in       = raw_ff;
      r0_in        = r0_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      r3_in        = r3_ff;
      b5_in        = b5_ff;
      val_in       = val_ff;
      err_in       = err_ff;
      mul_en       = 1'b0;
      mul_a        = r0_ff;
      mul_b        = r0_ff;
      div_req      = '0;
      div_dividend = r1_ff;
      div_divisor  = r2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_err_in   = rsp_err_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_port.operation;
               raw_in   = req_port.raw_reading;
               err_in   = 1'b0;
               state_in = (req_port.operation == OP_PRESSURE) ? ST_P_B6 : ST_T_DIFF;
            end
         end
         // temperature: x1, divide, b5
         ST_T_DIFF: begin
            r0_in    = {{(WORD_W-UT_W){1'b0}}, raw_ff[UT_W-1:0]} - ac6;
            state_in = ST_T_MUL;
         end
         ST_T_MUL: begin
            mul_en   = 1'b1;
            mul_a    = r0_ff;
            mul_b    = ac5;
            state_in = ST_T_X1;
         end
         ST_T_X1: begin
            r1_in    = word_type'($signed(prod) >>> 15);
            state_in = ST_T_DEN;
         end
         ST_T_DEN: begin
            r2_in    = r1_ff + md;
            state_in = ST_T_CHK;
         end
         ST_T_CHK: begin
            if (r2_ff == '0) begin
               val_in   = '0;
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               div_req.start       = 1'b1;
               div_req.signed_mode = 1'b1;
               div_dividend        = mc << 11;
               div_divisor         = r2_ff;
               state_in            = ST_T_DWAIT;
            end
         end
         ST_T_DWAIT: begin
            if (div_done) begin
               b5_in    = r1_ff + quot;
               state_in = ST_T_OUT;
            end
         end
         ST_T_OUT: begin
            val_in   = word_type'($signed(b5_ff + ROUND_T) >>> 4);
            state_in = ST_DONE;
         end
         // pressure: b6, b3, b4
         ST_P_B6: begin
            r0_in    = b5_ff - B6_OFFSET;
            state_in = ST_P_SQM;
         end
         ST_P_SQM: begin
            mul_en   = 1'b1;
            mul_a    = r0_ff;
            mul_b    = r0_ff;
            state_in = ST_P_SQ;
         end
         ST_P_SQ: begin
            r1_in    = word_type'($signed(prod) >>> 12);
            state_in = ST_P_X1M;
         end
         ST_P_X1M: begin
            mul_en   = 1'b1;
            mul_a    = b2;
            mul_b    = r1_ff;
            state_in = ST_P_X1;
         end
         ST_P_X1: begin
            r2_in    = word_type'($signed(prod) >>> 11);
            mul_en   = 1'b1;
            mul_a    = ac2;
            mul_b    = r0_ff;
            state_in = ST_P_X3;
         end
         ST_P_X3: begin
            r2_in    = r2_ff + word_type'($signed(prod) >>> 11);
            state_in = ST_P_B3A;
         end
         ST_P_B3A: begin
            r3_in    = (ac1 << 2) + r2_ff;
            mul_en   = 1'b1;
            mul_a    = ac3;
            mul_b    = r0_ff;
            state_in = ST_P_B3B;
         end
         ST_P_B3B: begin
            r3_in    = word_type'($signed((r3_ff << cfg.oversampling) + ROUND_2) >>> 2);
            r2_in    = word_type'($signed(prod) >>> 13);
            mul_en   = 1'b1;
            mul_a    = b1;
            mul_b    = r1_ff;
            state_in = ST_P_X3B;
         end
         ST_P_X3B: begin
            r2_in    = r2_ff + word_type'($signed(prod) >>> 16);
            state_in = ST_P_X3C;
         end
         ST_P_X3C: begin
            r2_in    = word_type'($signed(r2_ff + ROUND_2) >>> 2);
            state_in = ST_P_X3D;
         end
         ST_P_X3D: begin
            r2_in    = r2_ff + B4_BIAS;
            state_in = ST_P_B4M;
         end
         ST_P_B4M: begin
            mul_en   = 1'b1;
            mul_a    = ac4;
            mul_b    = r2_ff;
            state_in = ST_P_B4;
         end
         ST_P_B4: begin
            r2_in    = prod >> 15;
            state_in = ST_P_B7A;
         end
         // pressure: b7 and the unsigned divide
         ST_P_B7A: begin
            if (r2_ff == '0) begin
               val_in   = '0;
               err_in   = 1'b1;
               state_in = ST_DONE;
            end else begin
               r1_in    = {{(WORD_W-RAW_W){1'b0}}, raw_ff} - r3_ff;
               state_in = ST_P_B7M;
            end
         end
         ST_P_B7M: begin
            mul_en   = 1'b1;
            mul_a    = r1_ff;
            mul_b    = b7_scale(cfg.oversampling);
            state_in = ST_P_B7;
         end
         ST_P_B7: begin
            r1_in               = prod;
            div_req.start       = 1'b1;
            div_req.signed_mode = 1'b0;
            div_dividend        = prod[WORD_W-1] ? prod : (prod << 1);
            div_divisor         = r2_ff;
            state_in            = ST_P_DWAIT;
         end
         ST_P_DWAIT: begin
            if (div_done) begin
               r0_in    = r1_ff[WORD_W-1] ? (quot << 1) : quot;
               state_in = ST_P_F1M;
            end
         end
         // pressure: final correction
         ST_P_F1M: begin
            mul_en   = 1'b1;
            mul_a    = word_type'($signed(r0_ff) >>> 8);
            mul_b    = word_type'($signed(r0_ff) >>> 8);
            state_in = ST_P_F1;
         end
         ST_P_F1: begin
            mul_en   = 1'b1;
            mul_a    = prod;
            mul_b    = P_COEF_SQ;
            state_in = ST_P_F1S;
         end
         ST_P_F1S: begin
            r1_in    = word_type'($signed(prod) >>> 16);
            mul_en   = 1'b1;
            mul_a    = P_COEF_LIN;
            mul_b    = r0_ff;
            state_in = ST_P_F2;
         end
         ST_P_F2: begin
            r2_in    = word_type'($signed(prod) >>> 16);
            state_in = ST_P_S1;
         end
         ST_P_S1: begin
            r1_in    = r1_ff + r2_ff;
            state_in = ST_P_S2;
         end
         ST_P_S2: begin
            r1_in    = word_type'($signed(r1_ff + P_COEF_OFS) >>> 4);
            state_in = ST_P_FIN;
         end
         ST_P_FIN: begin
            val_in   = r0_ff + r1_ff;
            state_in = ST_DONE;
         end
         // hand the word to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = op_ff;
               rsp_value_in = val_ff;
               rsp_err_in   = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         b5_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         b5_ff        <= b5_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      raw_ff       <= raw_in;
      r0_ff        <= r0_in;
      r1_ff        <= r1_in;
      r2_ff        <= r2_in;
      r3_ff        <= r3_in;
      val_ff       <= val_in;
      err_ff       <= err_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.result_kind       = rsp_kind_ff;
   assign rsp_port.compensated_value = rsp_value_ff;
   assign rsp_port.divide_error      = rsp_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> rsp_value_ff == '0)
      else $error("divide error word carries a non-zero value");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted word did not start the sequencer");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_T_DWAIT || state_ff == ST_P_DWAIT))
      else $error("divider finished outside a wait step");

   a_b5_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_T_DWAIT) |=> $stable(b5_ff))
      else $error("stored B5 changed outside a temperature word");

endmodule

`default_nettype wire

### rtl/barometric_pressure_compensation.sv
`default_nettype none

// Barometric pressure compensation, datasheet integer scheme. A temperature word
// (operation 0) turns the raw 16-bit reading into tenths of a degree and keeps
// B5 for later pressure words; a pressure word (operation 1) turns the raw
// reading into pascal from the stored B5, the calibration registers and the
// oversampling setting. One word is worked at a time. The divider works through
// 32 quotient-bit steps and one sign step; the other steps share one registered
// 32x32 multiplier. A zero divisor skips the divide and the steps after it.
// req_port.ready is high while the sequencer is idle, and the finished word
// sits in an output register so the next word may be taken while it waits.
// A zero divisor gives value 0 with divide_error set and, for temperature,
// leaves B5 unchanged. The user must write calibration through the csr_ port
// only while no word is in flight; the block itself does not enforce this.

module barometric_pressure_compensation import bpc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bpc_req_if.sink                     req_port,
   bpc_rsp_if.source                   rsp_port,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type cfg_ff, cfg_in;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_OVERSAMPLING:    cfg_in.oversampling    = csr_write_data[OSS_W-1:0];
            CSR_CAL_TEMPERATURE: cfg_in.cal_temperature = csr_write_data;
            CSR_CAL_PRESSURE_A:  cfg_in.cal_pressure_a  = csr_write_data;
            CSR_CAL_PRESSURE_B:  cfg_in.cal_pressure_b  = csr_write_data[31:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bpc_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_port (req_port),
      .rsp_port (rsp_port)
   );

endmodule

`default_nettype wire

### test/barometric_pressure_compensation_test.sv
`timescale 1ns / 1ps

module barometric_pressure_compensation_test;
   import bpc_pkg::*;

   typedef struct packed {
      logic             operation;
      logic [RAW_W-1:0] raw_reading;
   } raw_word_type;

   typedef struct packed {
      logic     result_kind;
      word_type value;
      logic     divide_error;
   } reading_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_OVERSAMPLING;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   bpc_req_if req_if ();
   bpc_rsp_if rsp_if ();

   barometric_pressure_compensation uut (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_if),
      .rsp_port         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // our copy of the block's registers and its stored B5
   logic [1:0]  oss_setting  = '0;
   logic [63:0] cal_t_words  = '0;
   logic [63:0] cal_pa_words = '0;
   logic [31:0] cal_pb_words = '0;
   word_type    stored_b5    = '0;

   raw_word_type raw_queue[$];
   reading_type  awaited_readings[$];
   reading_type  oldest_reading;
   int           error_count = 0;
   bit           steady = 1'b0;

   function automatic word_type shift_signed(input word_type x, input int unsigned s);
      logic signed [31:0] sx;
      sx = x;
      return sx >>> s;
   endfunction

   // temperature: B5 from UT and the AC5/AC6/MC/MD words; B5 kept on success
   function automatic reading_type compensate_temperature(input logic [15:0] ut);
      word_type    ac5, ac6, mc, md, x1, den, mc_shifted, b5;
      longint      quotient;
      reading_type r;
      ac5 = {16'b0, cal_t_words[63:48]};
      ac6 = {16'b0, cal_t_words[47:32]};
      mc  = {{16{cal_t_words[31]}}, cal_t_words[31:16]};
      md  = {{16{cal_t_words[15]}}, cal_t_words[15:0]};
      x1  = shift_signed(({16'b0, ut} - ac6) * ac5, 15);
      den = x1 + md;
      r.result_kind = OP_TEMPERATURE;
      if (den == '0) begin
         r.value = '0;
         r.divide_error = 1'b1;
      end else begin
         mc_shifted = mc << 11;
         quotient = longint'($signed(mc_shifted)) / longint'($signed(den));
         b5 = x1 + quotient[31:0];
         stored_b5 = b5;
         r.value = shift_signed(b5 + 32'd8, 4);
         r.divide_error = 1'b0;
      end
      return r;
   endfunction

   // pressure: B3/B4/B7 chain from the stored B5, then the second-order fix-up
   function automatic reading_type compensate_pressure(input logic [RAW_W-1:0] up);
      word_type    ac1, ac2, ac3, ac4, b1, b2;
      word_type    b6, sq, x1, x2, x3, b3, b4, b7, p, scale;
      reading_type r;
      ac1 = {{16{cal_pa_words[63]}}, cal_pa_words[63:48]};
      ac2 = {{16{cal_pa_words[47]}}, cal_pa_words[47:32]};
      ac3 = {{16{cal_pa_words[31]}}, cal_pa_words[31:16]};
      ac4 = {16'b0, cal_pa_words[15:0]};
      b1  = {{16{cal_pb_words[31]}}, cal_pb_words[31:16]};
      b2  = {{16{cal_pb_words[15]}}, cal_pb_words[15:0]};
      b6  = stored_b5 - 32'd4000;
      sq  = shift_signed(b6 * b6, 12);
      x1  = shift_signed(b2 * sq, 11);
      x2  = shift_signed(ac2 * b6, 11);
      x3  = x1 + x2;
      b3  = ac1 * 32'd4 + x3;
      b3  = shift_signed((b3 << oss_setting) + 32'd2, 2);
      x1  = shift_signed(ac3 * b6, 13);
      x2  = shift_signed(b1 * sq, 16);
      x3  = shift_signed(x1 + x2 + 32'd2, 2);
      b4  = (ac4 * (x3 + 32'd32768)) >> 15;
      r.result_kind = OP_PRESSURE;
      if (b4 == '0) begin
         r.value = '0;
         r.divide_error = 1'b1;
         return r;
      end
      scale = 32'd50000 >> oss_setting;
      b7 = ({13'b0, up} - b3) * scale;
      if (b7 < 32'h8000_0000)
         p = (b7 * 32'd2) / b4;
      else
         p = (b7 / b4) * 32'd2;
      x1 = shift_signed(p, 8) * shift_signed(p, 8);
      x1 = shift_signed(x1 * 32'd3038, 16);
      x2 = shift_signed(32'hFFFF_E343 * p, 16);
      r.value = p + shift_signed(x1 + x2 + 32'd3791, 4);
      r.divide_error = 1'b0;
      return r;
   endfunction

   task automatic flag_mismatch(input string detail);
      $display("mismatch at %0t ns: %s", $time, detail);
      error_count++;
   endtask

   task automatic write_register(input csr_index_type which, input logic [63:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= which;
      csr_write_data   <= value;
      case (which)
         CSR_OVERSAMPLING:    oss_setting  = value[1:0];
         CSR_CAL_TEMPERATURE: cal_t_words  = value;
         CSR_CAL_PRESSURE_A:  cal_pa_words = value;
         CSR_CAL_PRESSURE_B:  cal_pb_words = value[31:0];
         default: begin
            oss_setting = oss_setting;
         end
      endcase
   endtask

   // write all four registers, then drop the enable
   task automatic set_calibration(input logic [1:0] oss, input logic [63:0] cal_t,
                                  input logic [63:0] cal_pa, input logic [31:0] cal_pb);
      write_register(CSR_OVERSAMPLING, {62'b0, oss});
      write_register(CSR_CAL_TEMPERATURE, cal_t);
      write_register(CSR_CAL_PRESSURE_A, cal_pa);
      write_register(CSR_CAL_PRESSURE_B, {32'b0, cal_pb});
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_word(input logic op, input logic [RAW_W-1:0] raw);
      raw_queue.push_back('{operation: op, raw_reading: raw});
   endtask

   // hold until every word has gone through and its result has come back;
   // sample away from the rising edge so the driver's updates have settled
   task automatic wait_idle();
      @(negedge clock);
      while (raw_queue.size() != 0 || req_if.valid || awaited_readings.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      req_if.valid       = 1'b0;
      req_if.operation   = OP_TEMPERATURE;
      req_if.raw_reading = '0;
      rsp_if.ready       = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // driver: predict each accepted word, then present the next one or idle
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (req_if.operation == OP_TEMPERATURE)
               awaited_readings.push_back(compensate_temperature(req_if.raw_reading[15:0]));
            else
               awaited_readings.push_back(compensate_pressure(req_if.raw_reading));
         end
         if (!req_if.valid || req_if.ready) begin
            if (raw_queue.size() != 0 && (steady || $urandom_range(99) >= 19)) begin
               req_if.valid       <= 1'b1;
               req_if.operation   <= raw_queue[0].operation;
               req_if.raw_reading <= raw_queue[0].raw_reading;
               raw_queue.delete(0);
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // stall the result side at random
   always @(posedge clock) begin
      rsp_if.ready <= !reset && (steady || $urandom_range(99) >= 19);
   end

   // monitor: compare each result word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_readings.size() == 0) begin
            flag_mismatch($sformatf("unexpected word kind %0b value %0d",
                                    rsp_if.result_kind, rsp_if.compensated_value));
         end else begin
            oldest_reading = awaited_readings.pop_front();
            if (rsp_if.result_kind !== oldest_reading.result_kind)
               flag_mismatch($sformatf("result_kind %0b, want %0b",
                                       rsp_if.result_kind, oldest_reading.result_kind));
            if (rsp_if.compensated_value !== oldest_reading.value)
               flag_mismatch($sformatf("compensated_value %0d, want %0d (kind %0b)",
                                       rsp_if.compensated_value,
                                       $signed(oldest_reading.value),
                                       oldest_reading.result_kind));
            if (rsp_if.divide_error !== oldest_reading.divide_error)
               flag_mismatch($sformatf("divide_error %0b, want %0b",
                                       rsp_if.divide_error, oldest_reading.divide_error));
         end
      end
   end

   localparam logic [63:0] SHEET_CAL_T  = {16'd32757, 16'd23153, -16'sd8711, 16'd2868};
   localparam logic [63:0] SHEET_CAL_PA = {16'd408, -16'sd72, -16'sd14383, 16'd32741};
   localparam logic [31:0] SHEET_CAL_PB = {16'd6190, 16'd4};

   initial begin
      int          phase;
      int          count;
      int          n;
      logic [63:0] cal_t;
      logic [63:0] cal_pa;
      logic [31:0] cal_pb;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: pressure before any temperature, zero divisors on both paths
      queue_word(OP_PRESSURE, 19'h7FFFF);
      queue_word(OP_TEMPERATURE, 19'h00000);
      queue_word(OP_TEMPERATURE, 19'h7FFFF);
      wait_idle();

      // datasheet calibration; upper raw bits ignored for temperature
      set_calibration(2'd0, SHEET_CAL_T, SHEET_CAL_PA, SHEET_CAL_PB);
      queue_word(OP_TEMPERATURE, 19'd27898);
      queue_word(OP_PRESSURE, 19'd23843);
      queue_word(OP_TEMPERATURE, 19'd27898 | 19'h70000);
      queue_word(OP_PRESSURE, 19'h00000);
      queue_word(OP_PRESSURE, 19'h7FFFF);
      wait_idle();

      // highest oversampling
      set_calibration(2'd3, SHEET_CAL_T, SHEET_CAL_PA, SHEET_CAL_PB);
      queue_word(OP_PRESSURE, 19'd23843 << 3);
      queue_word(OP_PRESSURE, 19'h7FFFF);
      wait_idle();

      // temperature divisor cancels to zero: B5 must survive for the pressure word
      set_calibration(2'd3, {16'h8000, 16'h0000, 16'h1234, 16'hFF9C}, SHEET_CAL_PA,
                      SHEET_CAL_PB);
      queue_word(OP_TEMPERATURE, 19'd200);
      queue_word(OP_TEMPERATURE, 19'd100);
      queue_word(OP_PRESSURE, 19'd30000);
      wait_idle();

      // AC4 of zero gives a zero B4
      set_calibration(2'd1, SHEET_CAL_T, {SHEET_CAL_PA[63:16], 16'h0000}, SHEET_CAL_PB);
      queue_word(OP_TEMPERATURE, 19'h0FFFF);
      queue_word(OP_PRESSURE, 19'd12345);
      wait_idle();

      // extreme calibration words: wraparound throughout
      set_calibration(2'd2, '1, 64'h8000_8000_8000_FFFF, 32'h8000_8000);
      queue_word(OP_TEMPERATURE, 19'h0FFFF);
      queue_word(OP_PRESSURE, 19'h7FFFF);
      queue_word(OP_TEMPERATURE, 19'h00000);
      queue_word(OP_PRESSURE, 19'h00000);
      wait_idle();
      set_calibration(2'd0, 64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_FFFF, 32'h7FFF_7FFF);
      queue_word(OP_TEMPERATURE, 19'h05555);
      queue_word(OP_PRESSURE, 19'h2AAAA);
      wait_idle();

      // random phases: mostly plausible calibration, every third one arbitrary
      for (phase = 0; phase < 6; phase++) begin
         steady = (phase == 3);
         if (phase % 3 == 2) begin
            cal_t  = {$urandom, $urandom};
            cal_pa = {$urandom, $urandom};
            cal_pb = $urandom;
         end else begin
            cal_t  = {16'($urandom_range(20000, 35000)), 16'($urandom_range(15000, 30000)),
                      16'(-$urandom_range(8000, 12000)), 16'($urandom_range(1500, 3500))};
            cal_pa = {16'($urandom_range(200, 9000)), 16'(-$urandom_range(0, 1500)),
                      16'(-$urandom_range(12000, 16000)), 16'($urandom_range(30000, 35000))};
            cal_pb = {16'($urandom_range(5000, 7000)), 16'($urandom_range(0, 64))};
         end
         set_calibration(2'(phase % 4), cal_t, cal_pa, cal_pb);

         // temperature then a few pressures, with some arbitrary words mixed in
         count = 0;
         while (count < 125) begin
            if ($urandom_range(99) < 15) begin
               queue_word(1'($urandom_range(1)), 19'($urandom_range(19'h7FFFF)));
               count++;
            end else begin
               queue_word(OP_TEMPERATURE, 19'($urandom_range(15000, 40000)));
               count++;
               n = $urandom_range(1, 3);
               repeat (n) begin
                  queue_word(OP_PRESSURE, 19'(($urandom_range(20000, 65535) << oss_setting)
                                              | $urandom_range(0, (1 << oss_setting) - 1)));
                  count++;
               end
            end
         end
         wait_idle();
      end
      steady = 1'b0;

      repeat (100) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
